// File: rtl/sha256_message_hasher_assert.svh
// Assertion macros for the message hasher checker.
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH
// Check that an antecedent implies a consequent in the next cycle.
`define SHA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
// Check that an antecedent implies a consequent in the same cycle.
`define SHA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`endif

// File: rtl/shamh_pkg.sv
// Shared types, constants and the rotate function for the message hasher.
`timescale 1ns / 1ps
package shamh_pkg;
    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_OUT, ST_PAD
    } state_t;

    typedef enum logic [1:0] {
        SRC_DATA, SRC_ZERO, SRC_LEN_HI, SRC_LEN_LO
    } wsrc_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        push;      // store one word into the block buffer
        wsrc_t       src;
        logic        add_len;   // add this beat's bits to the length
        logic        load_wv;   // copy chain value into working vars
        logic        round;     // run one compression round
        logic        fold;      // add working vars into chain value
        logic        out_load;  // present digest word
        logic [2:0]  out_idx;
        logic        clear;     // back to initial state
    } cmd_t;

    typedef struct packed {
        logic [3:0] word_pos;
        logic [5:0] round_idx;
    } status_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
endpackage

// File: rtl/shamh_datapath.sv
// Block buffer, message schedule, round logic, chain value and digest output.
`timescale 1ns / 1ps
module shamh_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  shamh_pkg::cmd_t  cmd,
    input  logic [31:0]      in_word,
    input  logic [5:0]       in_bits,
    output shamh_pkg::status_t status,
    output logic [31:0]      out_word
);
    import shamh_pkg::*;

    logic [31:0] w_reg [16];
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [63:0] len_reg;
    logic [3:0]  pos_reg;
    logic [5:0]  rnd_reg;
    logic [31:0] out_reg;
    logic [31:0] push_word;
    logic [31:0] w_new, s0, s1, big0, big1, ch, maj, t1, t2;

    always_comb begin
        case (cmd.src)
            SRC_DATA:   push_word = in_word;
            SRC_LEN_HI: push_word = len_reg[63:32];
            SRC_LEN_LO: push_word = len_reg[31:0];
            default:    push_word = '0;
        endcase
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        big1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + big1 + ch + ROUND_K[rnd_reg] + w_reg[0];
        big0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = big0 + maj;
    end

    // Buffer acts as a sliding window during rounds: slot 0 is w[t].
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            w_reg[pos_reg] <= push_word;
        end else if (cmd.round) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_new;
        end
        if (cmd.load_wv) begin
            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
        end else if (cmd.round) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (cmd.out_load) out_reg <= h_reg[cmd.out_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= INIT_HASH[i];
            len_reg <= '0;
            pos_reg <= '0;
            rnd_reg <= '0;
        end else begin
            if (cmd.fold) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
            end
            if (cmd.add_len) len_reg <= len_reg + {58'd0, in_bits};
            if (cmd.push) pos_reg <= pos_reg + 4'd1;
            if (cmd.round) rnd_reg <= rnd_reg + 6'd1;
        end
    end

    assign status.word_pos  = pos_reg;
    assign status.round_idx = rnd_reg;
    assign out_word = out_reg;
endmodule

// File: rtl/shamh_controller.sv
// Controller: input intake, padding sequence, round counting and digest output.
`timescale 1ns / 1ps
module shamh_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               s_last,
    input  logic [2:0]         s_count,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [2:0]         m_index,
    output logic               m_last,
    input  shamh_pkg::status_t status,
    output shamh_pkg::cmd_t    cmd,
    output logic [5:0]         in_bits,
    output logic [1:0]         mode
);
    import shamh_pkg::*;

    // pad_reg: 0 no padding, 1 word with 0x80 at top still owed, 2 zero fill,
    // 3 low length word owed (then the final block)
    state_t      state_reg, state_next;
    logic [1:0]  pad_reg, pad_next;
    logic [2:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic [2:0]  cnt;

    assign cnt = (!s_last || s_count > 3'd4) ? 3'd4 : s_count;
    assign in_bits = {cnt, 3'b000};
    assign m_tvalid = valid_reg;
    assign m_index = idx_reg;
    assign m_last = valid_reg && (idx_reg == 3'd7);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pad_reg   <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pad_reg   <= pad_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pad_next   = pad_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        cmd        = '0;
        cmd.src    = SRC_DATA;
        s_tready   = 1'b0;
        mode       = 2'd0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.push    = 1'b1;
                    cmd.add_len = 1'b1;
                    // mode selects masking of the data word in the top level
                    mode = s_last ? 2'd1 : 2'd0;
                    if (s_last) pad_next = (cnt == 3'd4) ? 2'd1 : 2'd2;
                    if (status.word_pos == 4'd15) state_next = ST_LOAD;
                    else if (s_last) state_next = ST_PAD;
                end
            end
            ST_PAD: begin
                // padding pushes, one word a cycle
                cmd.push = 1'b1;
                if (pad_reg == 2'd1) begin
                    mode = 2'd2;
                    pad_next = 2'd2;
                end else if (pad_reg == 2'd3) begin
                    cmd.src = SRC_LEN_LO;
                end else if (status.word_pos == 4'd14) begin
                    cmd.src  = SRC_LEN_HI;
                    pad_next = 2'd3;
                end else begin
                    cmd.src = SRC_ZERO;
                end
                if (status.word_pos == 4'd15) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.load_wv = 1'b1;
                state_next  = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
                if (status.round_idx == 6'd63) state_next = ST_FOLD;
            end
            ST_FOLD: begin
                cmd.fold = 1'b1;
                if (pad_reg == 2'd3) begin
                    state_next = ST_OUT;
                    idx_next   = '0;
                end else if (pad_reg == 2'd0) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT: begin
                if (!valid_reg || m_tready) begin
                    if (valid_reg && idx_reg == 3'd7) begin
                        valid_next = 1'b0;
                        cmd.clear  = 1'b1;
                        pad_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.out_load = 1'b1;
                        cmd.out_idx  = valid_reg ? idx_reg + 3'd1 : 3'd0;
                        idx_next     = cmd.out_idx;
                        valid_next   = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// File: rtl/sha256_message_hasher.sv
// Top level of the SHA-256 message hasher.
//  channel | dir | fields (tdata low bit up)                   | tlast
//  s_      | in  | data_word[31:0], byte_count[34:32]          | last
//  m_      | out | digest_word[31:0], word_index[34:32]        | last_word
// Input is accepted only in the idle state; every 16th word starts a compression (a load,
// 64 rounds on the shared round unit and a fold), during which input waits.
// The last word adds padding pushes, one or two compressions and 8 output beats.
// Reset clears chain value, length and position at once; output stalls hold input.
`timescale 1ns / 1ps
module sha256_message_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_word[31:0], byte_count[34:32], zero
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero
    output logic        m_tlast
);
    import shamh_pkg::*;

    cmd_t        cmd;
    status_t     status;
    logic [5:0]  in_bits;
    logic [1:0]  mode;
    logic [31:0] mask, in_word, out_word;
    logic [2:0]  m_index;

    // Keep valid bytes, put the pad byte right after them; mode 2 gives the pad word alone.
    always_comb begin
        case (in_bits[5:3])
            3'd0:    mask = 32'h0;
            3'd1:    mask = 32'hff000000;
            3'd2:    mask = 32'hffff0000;
            3'd3:    mask = 32'hffffff00;
            default: mask = 32'hffffffff;
        endcase
        if (mode == 2'd2) in_word = {PAD_BYTE, 24'd0};
        else if (mode == 2'd1 && in_bits[5:3] != 3'd4)
            in_word = (s_tdata[31:0] & mask) | ({PAD_BYTE, 24'd0} >> in_bits);
        else in_word = s_tdata[31:0];
    end

    shamh_controller u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_last(s_tlast),
        .s_count(s_tdata[34:32]), .m_tvalid, .m_tready, .m_index,
        .m_last(m_tlast), .status, .cmd, .in_bits, .mode
    );

    shamh_datapath u_dp (
        .aclk, .aresetn, .cmd, .in_word, .in_bits, .status, .out_word
    );

    assign m_tdata = {5'd0, m_index, out_word};
endmodule

// File: rtl/sha256_message_hasher_checker.sv
// Port-level checker for the message hasher, bound to the top level.
`timescale 1ns / 1ps
`include "sha256_message_hasher_assert.svh"
module sha256_message_hasher_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);
    `SHA_ASSERT_NOW(a_last_idx, aclk, aresetn, m_tvalid && m_tlast, m_tdata[34:32] == 3'd7, "tlast off index 7")
    `SHA_ASSERT_NOW(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready, "input taken during output")
    `SHA_ASSERT_NEXT(a_idx_step, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1, "index skipped")
    `SHA_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled beat changed")
endmodule

bind sha256_message_hasher sha256_message_hasher_checker u_chk (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);

// File: dv/sha256_checker.sv
// Checker for the message hasher: predicts digests from input beats and compares output beats.
`timescale 1ns / 1ps
module sha256_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    output int          errors,
    output int          pending,
    output int          digests_seen
);
    import shamh_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        fin;
    } digest_beat_t;

    logic [31:0] chain [8];
    logic [31:0] blk [16];
    logic [63:0] msg_bits;
    logic [3:0]  slot;
    digest_beat_t digest_q[$];

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int t = 0; t < 16; t++) w[t] = blk[t];
        for (int t = 16; t < 64; t++)
            w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        for (int t = 0; t < 8; t++) v[t] = chain[t];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++) chain[t] = chain[t] + v[t];
    endtask

    task automatic push(input logic [31:0] w);
        blk[slot] = w;
        slot = slot + 4'd1;
        if (slot == 4'd0) compress();
    endtask

    task automatic restart();
        for (int k = 0; k < 8; k++) chain[k] = INIT_HASH[k];
        msg_bits = '0;
        slot = '0;
    endtask

    task automatic absorb_beat(input logic [31:0] data, input logic [2:0] cnt_in,
                               input logic fin);
        int cnt;
        logic [31:0] mask;
        cnt = (cnt_in > 3'd4 || !fin) ? 4 : int'(cnt_in);
        msg_bits = msg_bits + 64'(8 * cnt);
        if (!fin) begin
            push(data);
            return;
        end
        if (cnt == 4) begin
            push(data);
            push({PAD_BYTE, 24'h0});
        end else begin
            mask = (cnt == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * cnt));
            push((data & mask) | (32'(PAD_BYTE) << (24 - 8 * cnt)));
        end
        while (slot != 4'd14) push(32'h0);
        push(msg_bits[63:32]);
        push(msg_bits[31:0]);
        for (int k = 0; k < 8; k++) digest_q.push_back('{chain[k], 3'(k), k == 7});
        restart();
    endtask

    initial begin
        errors = 0;
        pending = 0;
        digests_seen = 0;
        restart();
    end

    always @(posedge aclk) begin
        digest_beat_t exp_b;
        int nerr;
        nerr = 0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected digest beat %h", m_tdata);
                    nerr++;
                end else begin
                    exp_b = digest_q.pop_front();
                    if (m_tdata[31:0] !== exp_b.word) begin
                        $error("digest_word expected %h actual %h", exp_b.word, m_tdata[31:0]);
                        nerr++;
                    end
                    if (m_tdata[34:32] !== exp_b.idx) begin
                        $error("word_index expected %0d actual %0d", exp_b.idx, m_tdata[34:32]);
                        nerr++;
                    end
                    if (m_tlast !== exp_b.fin) begin
                        $error("last_word expected %b actual %b", exp_b.fin, m_tlast);
                        nerr++;
                    end
                    if (exp_b.fin) digests_seen <= digests_seen + 1;
                end
            end
            if (s_tvalid && s_tready)
                absorb_beat(s_tdata[31:0], s_tdata[34:32], s_tlast);
        end
        errors  <= errors + nerr;
        pending <= digest_q.size();
    end
endmodule

// File: dv/tb_top.sv
// Testbench top: drives message words into the hasher and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    int          errors, pending, digests_seen;
    int          words_sent = 0;
    int          idle_cnt = 0;
    bit          calm = 1'b0;
    bit          hold_off = 1'b0;

    localparam int WATCHDOG = 20000;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sha256_message_hasher dut (.*);

    sha256_checker chk (.*);

    // receiver: random stalls, or a long hold-off while hold_off is set
    always @(posedge aclk) begin
        if (!aresetn || hold_off) m_tready <= 1'b0;
        else m_tready <= calm || ($urandom_range(99) >= 10);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG) begin
            $display("watchdog expired");
            $display("status: fail");
            $finish;
        end
    end

    // hold valid across back-to-back words; drop it only on an idle cycle
    task automatic send_word(input logic [31:0] data, input logic [2:0] cnt, input logic fin);
        while (!calm && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, cnt, data};
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // message of n words with random content; the last word carries byte count cnt
    task automatic send_message(input int n, input logic [2:0] cnt);
        for (int i = 0; i < n - 1; i++)
            send_word($urandom, 3'($urandom_range(7)), 1'b0);
        send_word($urandom, cnt, 1'b1);
    endtask

    initial begin
        int n;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // empty message, then extremes of data and last-word byte counts 1, 3, 4, 5 and 7
        send_word(32'hffffffff, 3'd0, 1'b1);
        send_word(32'hffffffff, 3'd1, 1'b1);
        send_word(32'h00000000, 3'd4, 1'b1);
        send_word(32'h61626300, 3'd3, 1'b1);
        send_word(32'hffffffff, 3'd2, 1'b0);
        send_word(32'hffffffff, 3'd7, 1'b1);
        send_word(32'h12345678, 3'd5, 1'b1);
        // lengths around the padding boundary: 13 words, 14 words, 14 words and 2 bytes, 16 words
        send_message(14, 3'd0);
        send_message(14, 3'd4);
        send_message(15, 3'd2);
        send_message(16, 3'd4);
        // receiver holds off while the sender keeps offering
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 4; i++) send_message(3, 3'($urandom_range(4)));
        join
        while (words_sent < 220) begin
            calm = (words_sent > 150 && words_sent < 190);
            n = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 17);
            send_message(n, 3'($urandom_range(7)));
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("sent %0d words, checked %0d digests", words_sent, digests_seen);
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// File: sha256_message_hasher.f
+incdir+rtl
rtl/shamh_pkg.sv
rtl/shamh_datapath.sv
rtl/shamh_controller.sv
rtl/sha256_message_hasher.sv
rtl/sha256_message_hasher_checker.sv
dv/sha256_checker.sv
dv/tb_top.sv
